[rtl/vscg_pkg.sv]
// ----------------------------------------------------------------------------
// vscg_pkg
// Shared types and constants of the voxel sphere command generator.
// ----------------------------------------------------------------------------
package vscg_pkg;

   localparam int MAX_RADIUS = 31;

   localparam int RADIUS_W = 5;
   localparam int BASE_W   = 7;
   localparam int OFFSET_W = 6;
   localparam int FLOOR_W  = 7;
   localparam int INDEX_W  = 6;
   localparam int COORD_W  = 7;   // signed cell offset, index minus radius
   localparam int AMOUNT_W = 8;
   localparam int POS_X_W  = 6;
   localparam int POS_Y_W  = 8;
   localparam int POS_Z_W  = 6;
   localparam int RSQ_W    = 2 * RADIUS_W;
   localparam int DIST_W   = 14;  // sum of three squared offsets
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int SLOTS    = 4;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 5'd10;
   localparam logic [BASE_W-1:0]   BASE_RST   = 7'h55;  // -43
   localparam logic [OFFSET_W-1:0] OFFSET_RST = 6'd13;
   localparam logic [FLOOR_W-1:0]  FLOOR_RST  = 7'h62;  // -30

   // result slots, in emission order
   localparam int SLOT_HEAD  = 0;
   localparam int SLOT_HEADX = 1;
   localparam int SLOT_PRINT = 2;
   localparam int SLOT_END   = 3;

   typedef enum logic [2:0] {
      CMD_SET_GANTRY = 3'd0,
      CMD_LAYER_DOWN = 3'd1,
      CMD_SET_HEAD_X = 3'd2,
      CMD_PRINT      = 3'd3,
      CMD_RESET_BED  = 3'd4,
      CMD_FINISHED   = 3'd5
   } vscg_cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS        = 2'd0,
      CSR_PLANE_BASE    = 2'd1,
      CSR_GANTRY_OFFSET = 2'd2,
      CSR_GANTRY_FLOOR  = 2'd3
   } vscg_csr_index_type;

   typedef struct packed {
      logic [RADIUS_W-1:0] radius;
      logic [BASE_W-1:0]   plane_base;
      logic [OFFSET_W-1:0] gantry_offset;
      logic [FLOOR_W-1:0]  gantry_floor;
   } vscg_cfg_type;

   // one visited cell, as handed from the walker to the emitter
   typedef struct packed {
      logic                gantry;
      logic                layer;
      logic                bed;
      logic                finish;
      logic [AMOUNT_W-1:0] target;
      logic [COORD_W-1:0]  kx;
      logic [COORD_W-1:0]  ky;
      logic [COORD_W-1:0]  kz;
      logic [POS_Y_W-1:0]  py;
      logic [POS_Z_W-1:0]  row;
      logic [INDEX_W-1:0]  side;
      logic [RSQ_W-1:0]    rsq;
   } vscg_cell_type;

   typedef struct packed {
      vscg_cmd_type        command;
      logic [AMOUNT_W-1:0] amount;
      logic [POS_X_W-1:0]  pos_x;
      logic [POS_Y_W-1:0]  pos_y;
      logic [POS_Z_W-1:0]  pos_z;
      logic                last;
   } vscg_rsp_type;

endpackage

[rtl/voxel_sphere_command_generator_top.sv]
// ----------------------------------------------------------------------------
// voxel_sphere_command_generator_top
// Walks a voxel cube of side 2r+1 and emits printer commands for a sphere.
// ----------------------------------------------------------------------------
// Each request item visits one cell of the cube (x fastest, then z, then y);
// start_req = 1 restarts at the first cell, start_req = 0 steps to the next,
// and a step while no job runs is swallowed without any response. A cell
// yields zero to four response items: gantry target or layer-down when it
// opens a plane or row, head-x and print-block when it lies inside the
// sphere, and bed reset or finished when it closes a plane or the job; last
// marks the final item of a cell. Requests are taken every cycle while the
// pipeline flows. The next cell is taken once the held cell's commands are
// out or as its last one enters the response register, which moves one
// command per cycle while rsp_stall is low. A request passes through the
// request register, the command hold stage and the response register.
// Registers are written through the csr port at any time the block is idle;
// csr_ready is always high.
module voxel_sphere_command_generator_top import vscg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_start_req,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_command,
   output logic [AMOUNT_W-1:0]   rsp_amount,
   output logic [POS_X_W-1:0]    rsp_pos_x,
   output logic [POS_Y_W-1:0]    rsp_pos_y,
   output logic [POS_Z_W-1:0]    rsp_pos_z,
   output logic                  rsp_last,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   vscg_cfg_type  cfg_ff, cfg_in;
   vscg_cell_type cell_rec;
   logic          cell_valid;
   logic          cell_take;
   vscg_rsp_type  rsp;

   // configuration registers: always ready, one write per cycle
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RADIUS:        cfg_in.radius        = csr_data[RADIUS_W-1:0];
            CSR_PLANE_BASE:    cfg_in.plane_base    = csr_data[BASE_W-1:0];
            CSR_GANTRY_OFFSET: cfg_in.gantry_offset = csr_data[OFFSET_W-1:0];
            CSR_GANTRY_FLOOR:  cfg_in.gantry_floor  = csr_data[FLOOR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius        <= RADIUS_RST;
         cfg_ff.plane_base    <= BASE_RST;
         cfg_ff.gantry_offset <= OFFSET_RST;
         cfg_ff.gantry_floor  <= FLOOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // scan state and per-cell record
   vscg_walker u_walker (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_start_req (req_start_req),
      .req_stall     (req_stall),
      .cell_rec      (cell_rec),
      .cell_valid    (cell_valid),
      .cell_take     (cell_take)
   );

   // sphere test and command sequencing, one command per cycle unless stalled
   vscg_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .cell_rec   (cell_rec),
      .cell_valid (cell_valid),
      .cell_take  (cell_take),
      .rsp        (rsp),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall)
   );

   // drive response fields from the response register
   assign rsp_command = rsp.command;
   assign rsp_amount  = rsp.amount;
   assign rsp_pos_x   = rsp.pos_x;
   assign rsp_pos_y   = rsp.pos_y;
   assign rsp_pos_z   = rsp.pos_z;
   assign rsp_last    = rsp.last;

endmodule

[rtl/vscg_walker.sv]
// ----------------------------------------------------------------------------
// vscg_walker
// Cell scan state: takes one item per cycle unless stalled by the emitter,
// steps the x/z/y indices and registers the cell record for the emitter.
// ----------------------------------------------------------------------------
module vscg_walker import vscg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  vscg_cfg_type  cfg,
   input  logic          req_valid,
   input  logic          req_start_req,
   output logic          req_stall,
   output vscg_cell_type cell_rec,
   output logic          cell_valid,
   input  logic          cell_take
);

   logic [INDEX_W-1:0] col_ff, col_in;
   logic [INDEX_W-1:0] row_ff, row_in;
   logic [INDEX_W-1:0] plane_ff, plane_in;
   logic               active_ff, active_in;
   logic               cell_valid_ff, cell_valid_in;
   vscg_cell_type      cell_ff, cell_in;

   logic               accept;
   logic               emit;
   logic [RADIUS_W-1:0] r;
   logic [INDEX_W-1:0] side;
   logic [INDEX_W-1:0] col, row, plane;
   logic               row_end, plane_end, job_end;
   logic [8:0]         py9, target_raw, floor9;

   assign req_stall  = cell_valid_ff && !cell_take;
   assign accept     = req_valid && !req_stall;
   assign emit       = accept && (req_start_req || active_ff);
   assign cell_rec   = cell_ff;
   assign cell_valid = cell_valid_ff;

   assign r     = (int'(cfg.radius) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : cfg.radius;
   assign side  = {r, 1'b0};
   assign col   = req_start_req ? '0 : col_ff;
   assign row   = req_start_req ? '0 : row_ff;
   assign plane = req_start_req ? '0 : plane_ff;

   assign row_end   = col >= side;
   assign plane_end = row_end && (row >= side);
   assign job_end   = plane_end && (plane >= side);

   // plane y and gantry target, kept one bit wider until the floor clamp
   assign py9        = {{2{cfg.plane_base[BASE_W-1]}}, cfg.plane_base} + {3'b000, plane};
   assign target_raw = py9 + {3'b000, cfg.gantry_offset};
   assign floor9     = {{2{cfg.gantry_floor[FLOOR_W-1]}}, cfg.gantry_floor};

   always_comb begin
      cell_in        = cell_ff;
      cell_in.gantry = (col == '0) && (row == '0);
      cell_in.layer  = (col == '0) && (row != '0);
      cell_in.finish = job_end;
      cell_in.bed    = plane_end && !job_end;
      cell_in.target = ($signed(target_raw) < $signed(floor9)) ? floor9[AMOUNT_W-1:0]
                                                               : target_raw[AMOUNT_W-1:0];
      cell_in.kx     = {1'b0, col} - {2'b00, r};
      cell_in.ky     = {1'b0, plane} - {2'b00, r};
      cell_in.kz     = {1'b0, row} - {2'b00, r};
      cell_in.py     = py9[POS_Y_W-1:0];
      cell_in.row    = row;
      cell_in.side   = side;
      cell_in.rsq    = RSQ_W'(r) * RSQ_W'(r);
   end

   // advance the scan: x, then z, then y
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      plane_in  = plane_ff;
      active_in = active_ff;
      if (emit) begin
         active_in = 1'b1;
         col_in    = col + INDEX_W'(1);
         row_in    = row;
         plane_in  = plane;
         if (row_end) begin
            col_in = '0;
            row_in = row + INDEX_W'(1);
            if (plane_end) begin
               row_in   = '0;
               plane_in = plane + INDEX_W'(1);
               if (job_end) begin
                  plane_in  = '0;
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      cell_valid_in = cell_valid_ff;
      if (emit) begin
         cell_valid_in = 1'b1;
      end else if (cell_take) begin
         cell_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         plane_ff      <= '0;
         active_ff     <= 1'b0;
         cell_valid_ff <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         plane_ff      <= plane_in;
         active_ff     <= active_in;
         cell_valid_ff <= cell_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         cell_ff <= cell_in;
      end
   end

endmodule

[rtl/vscg_emitter.sv]
// ----------------------------------------------------------------------------
// vscg_emitter
// Sphere test and command sequencing: holds one cell's pending commands and
// sends them one per cycle, unless the output stalls, through the result register.
// ----------------------------------------------------------------------------
module vscg_emitter import vscg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  vscg_cell_type cell_rec,
   input  logic          cell_valid,
   output logic          cell_take,
   output vscg_rsp_type  rsp,
   output logic          rsp_valid,
   input  logic          rsp_stall
);

   vscg_cell_type      held_ff;
   logic [SLOTS-1:0]   mask_ff, mask_in;
   vscg_rsp_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [DIST_W-1:0]  ext_x, ext_y, ext_z;
   logic [DIST_W-1:0]  sq_x, sq_y, sq_z, dist_sq;
   logic               in_sphere;
   logic [SLOTS-1:0]   new_mask;
   logic [SLOTS-1:0]   sel, rest;
   logic               out_load, pop, can_load;

   // squared distance of the incoming cell from the center
   assign ext_x     = {{(DIST_W-COORD_W){cell_rec.kx[COORD_W-1]}}, cell_rec.kx};
   assign ext_y     = {{(DIST_W-COORD_W){cell_rec.ky[COORD_W-1]}}, cell_rec.ky};
   assign ext_z     = {{(DIST_W-COORD_W){cell_rec.kz[COORD_W-1]}}, cell_rec.kz};
   assign sq_x      = ext_x * ext_x;
   assign sq_y      = ext_y * ext_y;
   assign sq_z      = ext_z * ext_z;
   assign dist_sq   = sq_x + sq_y + sq_z;
   assign in_sphere = dist_sq <= DIST_W'(cell_rec.rsq);

   always_comb begin
      new_mask             = '0;
      new_mask[SLOT_HEAD]  = cell_rec.gantry || cell_rec.layer;
      new_mask[SLOT_HEADX] = in_sphere;
      new_mask[SLOT_PRINT] = in_sphere;
      new_mask[SLOT_END]   = cell_rec.bed || cell_rec.finish;
   end

   // lowest pending slot goes next
   always_comb begin
      sel = '0;
      priority if (mask_ff[SLOT_HEAD])  sel[SLOT_HEAD]  = 1'b1;
      else if     (mask_ff[SLOT_HEADX]) sel[SLOT_HEADX] = 1'b1;
      else if     (mask_ff[SLOT_PRINT]) sel[SLOT_PRINT] = 1'b1;
      else if     (mask_ff[SLOT_END])   sel[SLOT_END]   = 1'b1;
      else                              sel             = '0;
   end

   assign rest      = mask_ff & ~sel;
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (mask_ff != '0) && out_load;
   assign can_load  = (mask_ff == '0) || (pop && (rest == '0));
   assign cell_take = cell_valid && can_load;
   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      mask_in = mask_ff;
      if (pop) begin
         mask_in = rest;
      end
      if (cell_take) begin
         mask_in = new_mask;
      end
   end

   always_comb begin
      rsp_in         = rsp_ff;
      rsp_in.command = CMD_LAYER_DOWN;
      rsp_in.amount  = '0;
      rsp_in.pos_x   = '0;
      rsp_in.pos_y   = '0;
      rsp_in.pos_z   = '0;
      rsp_in.last    = (rest == '0);
      unique case (1'b1)
         sel[SLOT_HEAD]: begin
            if (held_ff.gantry) begin
               rsp_in.command = CMD_SET_GANTRY;
               rsp_in.amount  = held_ff.target;
            end
         end
         sel[SLOT_HEADX]: begin
            rsp_in.command = CMD_SET_HEAD_X;
            rsp_in.amount  = {held_ff.kx[COORD_W-1], held_ff.kx};
         end
         sel[SLOT_PRINT]: begin
            rsp_in.command = CMD_PRINT;
            rsp_in.pos_x   = held_ff.kx[POS_X_W-1:0];
            rsp_in.pos_y   = held_ff.py;
            rsp_in.pos_z   = held_ff.row;
         end
         sel[SLOT_END]: begin
            if (held_ff.finish) begin
               rsp_in.command = CMD_FINISHED;
            end else begin
               rsp_in.command = CMD_RESET_BED;
               rsp_in.amount  = {2'b00, held_ff.side};
            end
         end
         default: begin
            rsp_in.last = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_take) begin
         held_ff <= cell_rec;
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
